[design/apl_pkg.sv]
// Shared constants, register codes and types for the average pooling block.
package apl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W      = 5;
    localparam int DIV_W      = 9;
    localparam int STEP_W     = 4;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_WINDOW   = 8;
    localparam int DEF_MAX_CHANNELS = 1024;

    localparam logic [8:0]  RST_IMAGE_WIDTH   = 9'd8;
    localparam logic [8:0]  RST_IMAGE_HEIGHT  = 9'd8;
    localparam logic [10:0] RST_CHANNEL_COUNT = 11'd1;
    localparam logic [3:0]  RST_WINDOW_SIZE   = 4'd2;
    localparam logic [3:0]  RST_STEP_SIZE     = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_WINDOW_SIZE   = 3'd3,
        REG_STEP_SIZE     = 3'd4
    } reg_index_t;

    // Window settings handed from the front end to the back end.
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [DIV_W-1:0] divisor;
    } win_cfg_t;

endpackage

[design/apl_fifo.sv]
// Small first-in first-out queue used between the pipeline parts.
module apl_fifo
    import apl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (32'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) + 1 == DEPTH) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) + 1 == DEPTH) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

[design/apl_front.sv]
// Front end: configuration registers, sample position tracking and window classification.
module apl_front
    import apl_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int CMD_W        = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  cmd_full,
    output logic                  cmd_push,
    output logic [CMD_W-1:0]      cmd_data,
    output win_cfg_t              win_cfg
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PLW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SR  = (MAX_WINDOW > 1) ? (MAX_WINDOW - 1) : 1;
    localparam int RSW = (SR > 1) ? $clog2(SR) : 1;
    localparam int CSW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CHW = $clog2(MAX_CHANNELS + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CW-1:0]       col;
        logic [RSW-1:0]      rslot;
        logic [CSW-1:0]      cslot;
        logic                vert;
        logic                emit;
        logic                last;
    } cmd_t;

    logic [8:0]        width_reg;
    logic [8:0]        height_reg;
    logic [10:0]       channels_reg;
    logic [3:0]        window_reg;
    logic [3:0]        step_reg;
    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    logic [PLW-1:0]    plane_reg;
    logic [RSW-1:0]    rslot_reg;
    logic [CSW-1:0]    cslot_reg;
    logic [STEP_W-1:0] phx_reg;
    logic [STEP_W-1:0] phy_reg;

    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [CHW-1:0]    ch_eff;
    logic [WIN_W-1:0]  f_eff;
    logic [STEP_W-1:0] s_eff;
    logic              fits_x;
    logic              fits_y;
    logic              row_end;
    logic              plane_end;
    logic              accept;
    logic [STEP_W-1:0] phx_inc;
    logic [STEP_W-1:0] phy_inc;
    cmd_t              cmd;

    // Out-of-range settings saturate to the supported range.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);

        if (channels_reg == '0)
            ch_eff = CHW'(1);
        else if (32'(channels_reg) > MAX_CHANNELS)
            ch_eff = CHW'(MAX_CHANNELS);
        else
            ch_eff = CHW'(channels_reg);

        if (window_reg == '0)
            f_eff = WIN_W'(1);
        else if (32'(window_reg) > MAX_WINDOW)
            f_eff = WIN_W'(MAX_WINDOW);
        else
            f_eff = WIN_W'(window_reg);

        s_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
    end

    assign win_cfg.window  = f_eff;
    assign win_cfg.divisor = DIV_W'(f_eff) * DIV_W'(f_eff);

    assign accept    = push && !cmd_full;
    assign fits_x    = (32'(col_reg) + 1 >= 32'(f_eff));
    assign fits_y    = (32'(row_reg) + 1 >= 32'(f_eff));
    assign row_end   = (32'(col_reg) + 1 == 32'(w_eff));
    assign plane_end = (32'(row_reg) + 1 == 32'(h_eff));
    assign phx_inc   = phx_reg + STEP_W'(1);
    assign phy_inc   = phy_reg + STEP_W'(1);

    // A window completes when it fits and both origin phases are zero; it is the
    // last of the frame when none fits further right or below, in the last plane.
    always_comb
    begin
        cmd.sample = sample;
        cmd.col    = col_reg;
        cmd.rslot  = rslot_reg;
        cmd.cslot  = cslot_reg;
        cmd.vert   = fits_y;
        cmd.emit   = fits_x && fits_y && (phx_reg == '0) && (phy_reg == '0);
        cmd.last   = cmd.emit
                     && (32'(col_reg) + 32'(s_eff) >= 32'(w_eff))
                     && (32'(row_reg) + 32'(s_eff) >= 32'(h_eff))
                     && (32'(plane_reg) + 1 >= 32'(ch_eff));
    end

    assign cmd_push = accept;
    assign cmd_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_IMAGE_WIDTH;
            height_reg   <= RST_IMAGE_HEIGHT;
            channels_reg <= RST_CHANNEL_COUNT;
            window_reg   <= RST_WINDOW_SIZE;
            step_reg     <= RST_STEP_SIZE;
            col_reg      <= '0;
            row_reg      <= '0;
            plane_reg    <= '0;
            rslot_reg    <= '0;
            cslot_reg    <= '0;
            phx_reg      <= '0;
            phy_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:   width_reg    <= cfg_data[8:0];
                REG_IMAGE_HEIGHT:  height_reg   <= cfg_data[8:0];
                REG_CHANNEL_COUNT: channels_reg <= cfg_data;
                REG_WINDOW_SIZE:   window_reg   <= cfg_data[3:0];
                REG_STEP_SIZE:     step_reg     <= cfg_data[3:0];
                default:           ;
            endcase
            // Any known register restarts the frame.
            if (cfg_index <= REG_STEP_SIZE)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                plane_reg <= '0;
                rslot_reg <= '0;
                cslot_reg <= '0;
                phx_reg   <= '0;
                phy_reg   <= '0;
            end
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_reg   <= '0;
                cslot_reg <= '0;
                phx_reg   <= '0;
                if (plane_end)
                begin
                    row_reg   <= '0;
                    rslot_reg <= '0;
                    phy_reg   <= '0;
                    plane_reg <= (32'(plane_reg) + 1 >= 32'(ch_eff)) ? '0
                                 : plane_reg + PLW'(1);
                end
                else
                begin
                    row_reg   <= row_reg + RW'(1);
                    rslot_reg <= (32'(rslot_reg) + 1 == SR) ? '0 : rslot_reg + RSW'(1);
                    if (fits_y)
                    begin
                        phy_reg <= (phy_inc == s_eff) ? '0 : phy_inc;
                    end
                end
            end
            else
            begin
                col_reg   <= col_reg + CW'(1);
                cslot_reg <= (32'(cslot_reg) + 1 == MAX_WINDOW) ? '0 : cslot_reg + CSW'(1);
                if (fits_x)
                begin
                    phx_reg <= (phx_inc == s_eff) ? '0 : phx_inc;
                end
            end
        end
    end

endmodule

[design/apl_back.sv]
// Back end: line store and column sums for each sample, window sum and serial divide for each completed window.
module apl_back
    import apl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int CMD_W      = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  win_cfg_t            win_cfg,
    input  logic                cmd_empty,
    input  logic [CMD_W-1:0]    cmd_data,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output logic [SAMPLE_W-1:0] res_average,
    output logic                res_last
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SR   = (MAX_WINDOW > 1) ? (MAX_WINDOW - 1) : 1;
    localparam int RSW  = (SR > 1) ? $clog2(SR) : 1;
    localparam int CSW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MW   = MAX_WINDOW;
    localparam int DEPTH = SR * MAX_WIDTH;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int VW   = SAMPLE_W + 1 + LW;
    localparam int TW   = SAMPLE_W + 1 + 2 * LW;
    localparam int CNTW = $clog2(TW + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CW-1:0]       col;
        logic [RSW-1:0]      rslot;
        logic [CSW-1:0]      cslot;
        logic                vert;
        logic                emit;
        logic                last;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_WRITE,
        S_SUM,
        S_SETUP,
        S_DIV,
        S_OUT
    } state_t;

    logic [SAMPLE_W-1:0]     store_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] mem_q_reg;
    logic signed [VW-1:0]    colsum_reg [MW];

    state_t                  state_reg;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_in;
    logic [WIN_W-1:0]        k_reg;
    logic signed [VW-1:0]    vsum_reg;
    logic signed [TW-1:0]    total_reg;
    logic [TW-1:0]           mag_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic [CNTW-1:0]         cnt_reg;

    logic signed [31:0]      rd_slot;
    logic signed [31:0]      cs_slot;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [CSW-1:0]          cs_idx;
    logic [DIV_W:0]          shifted;
    logic                    ge;
    logic [SAMPLE_W-1:0]     quot16;

    assign cmd_in  = cmd_data;
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty;

    // Line store row of k rows back, and column sum slot of k columns back.
    always_comb
    begin
        rd_slot = 32'(cmd_reg.rslot) - 32'(k_reg);
        if (rd_slot < 0)
            rd_slot = rd_slot + SR;
        cs_slot = 32'(cmd_reg.cslot) - 32'(k_reg);
        if (cs_slot < 0)
            cs_slot = cs_slot + MW;
        rd_addr = AW'(rd_slot * MAX_WIDTH + 32'(cmd_reg.col));
        wr_addr = AW'(32'(cmd_reg.rslot) * MAX_WIDTH + 32'(cmd_reg.col));
        cs_idx  = CSW'(cs_slot);
    end

    assign shifted = {rem_reg, mag_reg[TW-1]};
    assign ge      = (shifted >= {1'b0, win_cfg.divisor});
    assign quot16  = mag_reg[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            mem_q_reg <= store_mem[rd_addr];
        end
        if (state_reg == S_WRITE)
        begin
            store_mem[wr_addr] <= cmd_reg.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            k_reg       <= '0;
            vsum_reg    <= '0;
            total_reg   <= '0;
            mag_reg     <= '0;
            rem_reg     <= '0;
            neg_reg     <= 1'b0;
            cnt_reg     <= '0;
            res_push    <= 1'b0;
            res_average <= '0;
            res_last    <= 1'b0;
            for (int i = 0; i < MW; i++)
            begin
                colsum_reg[i] <= '0;
            end
        end
        else
        begin
            res_push <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg  <= cmd_in;
                        vsum_reg <= VW'($signed(cmd_in.sample));
                        k_reg    <= WIN_W'(1);
                        if (cmd_in.vert && (win_cfg.window > WIN_W'(1)))
                            state_reg <= S_READ;
                        else
                            state_reg <= S_WRITE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    vsum_reg <= vsum_reg + VW'(mem_q_reg);
                    if (k_reg + WIN_W'(1) < win_cfg.window)
                    begin
                        k_reg     <= k_reg + WIN_W'(1);
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    colsum_reg[cmd_reg.cslot] <= vsum_reg;
                    k_reg     <= '0;
                    total_reg <= '0;
                    state_reg <= cmd_reg.emit ? S_SUM : S_IDLE;
                end
                S_SUM:
                begin
                    total_reg <= total_reg + TW'(colsum_reg[cs_idx]);
                    k_reg     <= k_reg + WIN_W'(1);
                    if (k_reg + WIN_W'(1) == win_cfg.window)
                        state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    neg_reg   <= total_reg[TW-1];
                    mag_reg   <= total_reg[TW-1] ? TW'(-total_reg) : TW'(total_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= ge ? DIV_W'(shifted - {1'b0, win_cfg.divisor})
                                  : DIV_W'(shifted);
                    mag_reg <= {mag_reg[TW-2:0], ge};
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (32'(cnt_reg) == TW - 1)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!res_full)
                    begin
                        res_push    <= 1'b1;
                        res_average <= neg_reg ? (~quot16 + SAMPLE_W'(1)) : quot16;
                        res_last    <= cmd_reg.last;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A result is only ever written into a queue that had room.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> $past(!res_full))
        else $error("result written while result queue was full");

    // Line store reads stay within the previous window rows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (k_reg != '0) && (k_reg < win_cfg.window))
        else $error("line store row offset out of window");

    // The divider never runs with a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (win_cfg.divisor != '0))
        else $error("divide started with zero divisor");

    // Only emitting samples reach the window sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> cmd_reg.emit)
        else $error("window sum for a sample that completes no window");

endmodule

[design/average_pooling_2d_forward.sv]
// Top level of the streaming 2-D average pooling block (forward pass).
//
// Samples enter through a queue-style port: drive sample and push, and a request
// is taken at a rising edge where push is high and full is low. Samples come in
// raster order within each channel plane, plane after plane. Results leave the
// same way: while empty is low, average and frame_end show the oldest result,
// and it is taken at an edge where pop is high. frame_end marks the last window
// of the last channel plane.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; a write to a known register also restarts the frame at row 0, plane 0.
// Write it only while the block is idle.
// The front end tracks positions and classifies each sample; a short command
// queue feeds the back end, which does the work one sample at a time. A sample
// on row F-1 or later reads the F-1 rows above it from the line store in turn (one
// memory port, one read per row), and a sample that closes a window adds the
// summing of F column sums and a serial divide of TW bits, TW being 23 with the
// default window limit. Reset returns the registers to their defaults and
// empties both queues. A stalled receiver fills the result queue, the back end
// waits, and then the command queue fills and full is raised; no result is lost.
module average_pooling_2d_forward
    import apl_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_W-1:0]   sample,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [SAMPLE_W-1:0]   average,
    output logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SR    = (MAX_WINDOW > 1) ? (MAX_WINDOW - 1) : 1;
    localparam int RSW   = (SR > 1) ? $clog2(SR) : 1;
    localparam int CSW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMD_W = SAMPLE_W + CW + RSW + CSW + 3;
    localparam int RES_W = SAMPLE_W + 1;

    logic                cmd_push;
    logic                cmd_full;
    logic [CMD_W-1:0]    cmd_wdata;
    logic                cmd_pop;
    logic                cmd_empty;
    logic [CMD_W-1:0]    cmd_rdata;
    win_cfg_t            win_cfg;
    logic                res_push;
    logic                res_full;
    logic [SAMPLE_W-1:0] res_average;
    logic                res_last;
    logic [RES_W-1:0]    res_rdata;

    // Registers can always be written; the block is idle by contract.
    assign cfg_ready = 1'b1;
    assign full      = cmd_full;

    apl_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS),
        .CMD_W        (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wdata),
        .win_cfg   (win_cfg)
    );

    // Command queue between classification and processing.
    apl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_rdata)
    );

    apl_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_cfg     (win_cfg),
        .cmd_empty   (cmd_empty),
        .cmd_data    (cmd_rdata),
        .cmd_pop     (cmd_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_average (res_average),
        .res_last    (res_last)
    );

    // Result queue decouples the back end from a stalled receiver.
    apl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata ({res_average, res_last}),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    assign average   = res_rdata[RES_W-1:1];
    assign frame_end = res_rdata[0];

endmodule
